// ===== rtl/integer_to_radix_ascii_core_defines.svh =====
// Assertion macros shared by the integer to radix ASCII RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itra_pkg.sv =====
// Shared types, constants and helpers for the integer to radix ASCII block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

	localparam int VALUE_W       = 64;
	localparam int RADIX_W       = 8;
	localparam int BASE_W        = 5;
	localparam int DIGIT_W       = 4;
	localparam int CHAR_W        = 8;
	localparam int BIT_CNT_W     = $clog2(VALUE_W);
	localparam int MAX_DIGITS_DEF = 64;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 8'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'd55;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic bad;
		logic neg;
	} emit_cmd_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		return (d < DIGIT_TEN) ? (CHAR_ZERO + ext) : (CHAR_ALPHA + ext);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/itra_digit_ram.sv =====
// Digit store: one write port, one registered read port.
// Depends on itra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itra_digit_ram #(
	parameter int DEPTH = itra_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
	input  wire logic [itra_pkg::DIGIT_W-1:0]       wr_data,
	input  wire logic                               rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
	output      logic [itra_pkg::DIGIT_W-1:0]       rd_data
);

	logic [itra_pkg::DIGIT_W-1:0] mem [DEPTH];
	logic [itra_pkg::DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/itra_divider.sv =====
// Bit-serial long division of a 64-bit magnitude by a small base, one digit per pass.
// Depends on itra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itra_divider #(
	parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [itra_pkg::VALUE_W-1:0]          dividend,
	input  wire logic [itra_pkg::BASE_W-1:0]           base,
	output      logic                                  wr_en,
	output      logic [$clog2(MAX_DIGITS)-1:0]         wr_addr,
	output      logic [itra_pkg::DIGIT_W-1:0]          wr_data,
	output      logic                                  done,
	output      logic [$clog2(MAX_DIGITS+1)-1:0]       count
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int AW    = $clog2(MAX_DIGITS);

	logic                               busy_q;
	logic                               done_q;
	logic                               nz_q;
	logic [itra_pkg::VALUE_W-1:0]       rem_q;
	logic [itra_pkg::DIGIT_W-1:0]       part_q;
	logic [itra_pkg::BIT_CNT_W-1:0]     bit_q;
	logic [CNT_W-1:0]                   cnt_q;

	logic [itra_pkg::BASE_W-1:0]        trial;
	logic [itra_pkg::BASE_W-1:0]        diff;
	logic                               ge;
	logic [itra_pkg::DIGIT_W-1:0]       part_n;
	logic                               nz_n;
	logic                               bit_last;
	logic                               finish;

	assign trial    = {part_q, rem_q[itra_pkg::VALUE_W-1]};
	assign ge       = (trial >= base);
	assign diff     = trial - base;
	assign part_n   = ge ? diff[itra_pkg::DIGIT_W-1:0] : trial[itra_pkg::DIGIT_W-1:0];
	assign nz_n     = nz_q | ge;
	assign bit_last = (bit_q == itra_pkg::BIT_CNT_W'(itra_pkg::VALUE_W - 1));
	assign finish   = bit_last && (!nz_n || (cnt_q == CNT_W'(MAX_DIGITS - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			nz_q   <= 1'b0;
			rem_q  <= '0;
			part_q <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				nz_q   <= 1'b0;
				rem_q  <= dividend;
				part_q <= '0;
				bit_q  <= '0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				rem_q <= {rem_q[itra_pkg::VALUE_W-2:0], ge};
				bit_q <= bit_q + 1'b1;
				if (bit_last) begin
					part_q <= '0;
					nz_q   <= 1'b0;
					cnt_q  <= cnt_q + 1'b1;
					if (finish) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					part_q <= part_n;
					nz_q   <= nz_n;
				end
			end
		end
	end

	assign wr_en   = busy_q && bit_last;
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_data = part_n;
	assign done    = done_q;
	assign count   = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/itra_emitter.sv =====
// Character sequencer: reads digits most significant first and drives the output register.
// Depends on itra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itra_emitter #(
	parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire itra_pkg::emit_cmd_t                   cmd,
	input  wire logic [$clog2(MAX_DIGITS+1)-1:0]       count,
	output      logic                                  busy,
	output      logic                                  rd_en,
	output      logic [$clog2(MAX_DIGITS)-1:0]         rd_addr,
	input  wire logic [itra_pkg::DIGIT_W-1:0]          rd_data,
	output      logic                                  out_valid,
	input  wire logic                                  out_stall,
	output      logic [itra_pkg::CHAR_W-1:0]           character,
	output      logic                                  last,
	output      logic                                  bad_radix
);

	localparam int AW = $clog2(MAX_DIGITS);

	logic                          busy_q;
	logic                          bad_pend_q;
	logic                          neg_pend_q;
	logic [AW-1:0]                 idx_q;

	logic                          valid_s1;
	logic                          digit_s1;
	logic [itra_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;
	logic                          bad_s1;

	logic                          out_valid_q;
	logic [itra_pkg::CHAR_W-1:0]   char_q;
	logic                          last_q;
	logic                          bad_q;

	logic                          out_load;
	logic                          s1_free;
	logic                          issue;

	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_free  = !valid_s1 || out_load;
	assign issue    = busy_q && s1_free;
	assign rd_en    = issue && !bad_pend_q && !neg_pend_q;
	assign rd_addr  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			bad_pend_q <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (cmd.start) begin
				busy_q     <= 1'b1;
				bad_pend_q <= cmd.bad;
				neg_pend_q <= cmd.neg;
				idx_q      <= AW'(count - 1'b1);
			end else if (issue) begin
				if (bad_pend_q) begin
					bad_pend_q <= 1'b0;
					busy_q     <= 1'b0;
				end else if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			digit_s1 <= !bad_pend_q && !neg_pend_q;
			char_s1  <= bad_pend_q ? itra_pkg::CHAR_NONE : itra_pkg::CHAR_MINUS;
			last_s1  <= bad_pend_q || (!neg_pend_q && (idx_q == '0));
			bad_s1   <= bad_pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= digit_s1 ? itra_pkg::digit_char(rd_data) : char_s1;
			last_q <= last_s1;
			bad_q  <= bad_s1;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule

`default_nettype wire

// ===== rtl/integer_to_radix_ascii_core.sv =====
// Integer to radix ASCII converter, top level: radix register, control FSM, datapath.
// Depends on itra_pkg, itra_divider, itra_digit_ram, itra_emitter and the defines header.
//
// Usage:
//   Write the number base on the config channel (cfg_valid/cfg_ready, data on radix)
//   while the block is idle; it resets to 10. Present a signed 64-bit value on the
//   input channel (in_valid/in_stall/value). The block returns one transaction per
//   character on the output channel (out_valid/out_stall/character/last/bad_radix),
//   most significant digit first, with last set on the final character. In base 10
//   a negative value starts with '-'. A base outside 2..16 gives one transaction
//   with character 0, last and bad_radix set.
//   Each digit costs one bit-serial division pass over all 64 bits of the magnitude;
//   characters then leave one per cycle while the receiver does not stall. in_stall
//   drops after the final character enters the read stage, once the emitter's busy
//   flag and then the control state have updated; a stalled receiver delays that.
//   A receiver stall holds the output register and backs up the digit read pipeline.
//   Reset clears the control state and empties the output; the radix returns to 10.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_ascii_core_defines.svh"

module integer_to_radix_ascii_core #(
	parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [itra_pkg::RADIX_W-1:0]          radix,
	input  wire logic                                  in_valid,
	output      logic                                  in_stall,
	input  wire logic signed [itra_pkg::VALUE_W-1:0]   value,
	output      logic                                  out_valid,
	input  wire logic                                  out_stall,
	output      logic [itra_pkg::CHAR_W-1:0]           character,
	output      logic                                  last,
	output      logic                                  bad_radix
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int AW    = $clog2(MAX_DIGITS);

	itra_pkg::state_t               state_q;
	itra_pkg::state_t               state_n;
	logic [itra_pkg::RADIX_W-1:0]   radix_q;
	logic [itra_pkg::BASE_W-1:0]    base_q;
	logic                           neg_q;

	logic [itra_pkg::VALUE_W-1:0]   value_u;
	logic [itra_pkg::VALUE_W-1:0]   magnitude;
	logic                           in_accept;
	logic                           radix_bad;
	logic                           value_neg;
	logic                           div_start;
	itra_pkg::emit_cmd_t            emit_cmd;

	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [itra_pkg::DIGIT_W-1:0]   wr_data;
	logic                           div_done;
	logic [CNT_W-1:0]               div_count;
	logic                           emit_busy;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic [itra_pkg::DIGIT_W-1:0]   rd_data;

	assign cfg_ready = 1'b1;
	assign value_u   = value;
	assign in_accept = in_valid && !in_stall;
	assign radix_bad = (radix_q < itra_pkg::RADIX_MIN) || (radix_q > itra_pkg::RADIX_MAX);
	assign value_neg = (radix_q == itra_pkg::RADIX_DEC) && value_u[itra_pkg::VALUE_W-1];
	assign magnitude = value_neg ? (~value_u + 1'b1) : value_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itra_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itra_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			base_q <= radix_q[itra_pkg::BASE_W-1:0];
			neg_q  <= value_neg;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_n = radix_bad ? itra_pkg::ST_EMIT : itra_pkg::ST_DIVIDE;
				end
			end
			itra_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_n = itra_pkg::ST_EMIT;
				end
			end
			itra_pkg::ST_EMIT: begin
				if (!emit_busy) begin
					state_n = itra_pkg::ST_IDLE;
				end
			end
			default: state_n = itra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		emit_cmd  = '0;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				div_start      = in_accept && !radix_bad;
				emit_cmd.start = in_accept && radix_bad;
				emit_cmd.bad   = 1'b1;
			end
			itra_pkg::ST_DIVIDE: begin
				emit_cmd.start = div_done;
				emit_cmd.neg   = neg_q;
			end
			itra_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	itra_divider #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (magnitude),
		.base     (base_q),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.done     (div_done),
		.count    (div_count)
	);

	itra_digit_ram #(
		.DEPTH(MAX_DIGITS)
	) u_digit_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	itra_emitter #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (emit_cmd),
		.count     (div_count),
		.busy      (emit_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last),
		.bad_radix (bad_radix)
	);

	`ITRA_ASSERT_NXT(a_done_to_emit, div_done, state_q == itra_pkg::ST_EMIT, "divider done outside DIVIDE")
	`ITRA_ASSERT_IMP(a_start_idle_emitter, emit_cmd.start, !emit_busy, "emitter restarted while busy")
	`ITRA_ASSERT_IMP(a_count_range, div_done, (div_count != '0) && (div_count <= CNT_W'(MAX_DIGITS)), "digit count out of range")
	`ITRA_ASSERT_IMP(a_bad_shape, out_valid && bad_radix, (character == itra_pkg::CHAR_NONE) && last, "bad radix transaction malformed")

endmodule

`default_nettype wire
